// ----- rtl/mgcb_pkg.sv -----
package mgcb_pkg;

	// Table geometry
	localparam int TRACKS = 64;
	localparam int BANKS  = 3;
	localparam int DEPTH  = BANKS * TRACKS;
	localparam int ADDR_W = $clog2(DEPTH);

	// track_index is 8 bits; it is compared zero-extended against a 9-bit limit
	localparam logic [8:0] TRACK_LIM = 9'(TRACKS);

	localparam logic [15:0] UNITY_GAIN = 16'h8000;

	// Request modes; codes 6 and 7 answer like a slot read
	localparam logic [2:0] MODE_SET_MUTE = 3'd0;
	localparam logic [2:0] MODE_SET_GAIN = 3'd1;
	localparam logic [2:0] MODE_SET_BOTH = 3'd2;
	localparam logic [2:0] MODE_READ     = 3'd3;
	localparam logic [2:0] MODE_KEY_EFF  = 3'd4;
	localparam logic [2:0] MODE_BGM_EFF  = 3'd5;

	// Bank codes
	localparam logic [1:0] BANK_PLAYER = 2'd0;
	localparam logic [1:0] BANK_DRAFT  = 2'd1;
	localparam logic [1:0] BANK_BGM    = 2'd2;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_PLAYER_AREA_MUTE   = 3'd0;
	localparam logic [2:0] REG_DRAFT_AREA_MUTE    = 3'd1;
	localparam logic [2:0] REG_BGM_AREA_MUTE      = 3'd2;
	localparam logic [2:0] REG_BGM_AREA_GAIN      = 3'd3;
	localparam logic [2:0] REG_UNBOUND_GROUP_MUTE = 3'd4;
	localparam logic [2:0] REG_UNBOUND_GROUP_GAIN = 3'd5;
	localparam logic [2:0] REG_BOUND_GROUP_MUTE   = 3'd6;
	localparam logic [2:0] REG_BOUND_GROUP_GAIN   = 3'd7;

	// One table slot
	typedef struct packed {
		logic        mute;
		logic [15:0] gain;
	} slot_t;

	localparam slot_t SLOT_RESET = '{mute: 1'b0, gain: UNITY_GAIN};

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL
	} st_t;

endpackage

// ----- rtl/mute_gain_control_bank.sv -----
// Mute and gain control table: three banks (player, draft, background music)
// of TRACKS slots, each a mute bit and an unsigned Q1.15 gain.
// Request channel (req_valid / req_stall): set a slot's mute, gain or both,
// read a slot, or ask for a key or background-music effective gain.
// Response channel (rsp_valid / rsp_stall): one response per request with
// the addressed slot, the effective gain (15 fraction bits) and index_valid.
// Timing: the response of an accepted request is registered, at the earliest,
// after the table read and the multiply. The sequencer takes one request at a
// time: the table read at the accept edge, then the shared 16x16 multiplier in
// the read state, then the load of the response register in the multiply state,
// then the idle state that can accept the next request.
// The response register lets the next request be accepted while a finished
// response still waits. While that response waits under rsp_stall, the
// sequencer stays in its multiply state and the response register holds it.
// Reset: every slot reads as unmuted with gain 1.0 (per-slot valid flops,
// no clearing pass), area and group mutes off, their gains at 1.0.
// Configuration over APB, register i at byte address 4*i; pready is always
// high. The user writes only while no request is in flight (not enforced).
module mute_gain_control_bank
	import mgcb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  mode,
	input  logic [1:0]  bank,
	input  logic [7:0]  track_index,
	input  logic        mute_value,
	input  logic [15:0] gain_value,
	input  logic        effect_group,
	input  logic        key_enabled,
	// response channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        slot_muted,
	output logic [15:0] slot_gain,
	output logic [16:0] effective_gain,
	output logic        index_valid,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// ---------------- configuration registers ----------------
	logic        player_area_mute_q, draft_area_mute_q, bgm_area_mute_q;
	logic [15:0] bgm_area_gain_q;
	logic        unbound_group_mute_q, bound_group_mute_q;
	logic [15:0] unbound_group_gain_q, bound_group_gain_q;
	logic        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_area_mute_q   <= 1'b0;
			draft_area_mute_q    <= 1'b0;
			bgm_area_mute_q      <= 1'b0;
			bgm_area_gain_q      <= UNITY_GAIN;
			unbound_group_mute_q <= 1'b0;
			unbound_group_gain_q <= UNITY_GAIN;
			bound_group_mute_q   <= 1'b0;
			bound_group_gain_q   <= UNITY_GAIN;
		end else if (cfg_we) begin
			unique case (paddr[4:2])
				REG_PLAYER_AREA_MUTE:   player_area_mute_q   <= pwdata[0];
				REG_DRAFT_AREA_MUTE:    draft_area_mute_q    <= pwdata[0];
				REG_BGM_AREA_MUTE:      bgm_area_mute_q      <= pwdata[0];
				REG_BGM_AREA_GAIN:      bgm_area_gain_q      <= pwdata[15:0];
				REG_UNBOUND_GROUP_MUTE: unbound_group_mute_q <= pwdata[0];
				REG_UNBOUND_GROUP_GAIN: unbound_group_gain_q <= pwdata[15:0];
				REG_BOUND_GROUP_MUTE:   bound_group_mute_q   <= pwdata[0];
				REG_BOUND_GROUP_GAIN:   bound_group_gain_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (paddr[4:2])
			REG_PLAYER_AREA_MUTE:   prdata = {31'd0, player_area_mute_q};
			REG_DRAFT_AREA_MUTE:    prdata = {31'd0, draft_area_mute_q};
			REG_BGM_AREA_MUTE:      prdata = {31'd0, bgm_area_mute_q};
			REG_BGM_AREA_GAIN:      prdata = {16'd0, bgm_area_gain_q};
			REG_UNBOUND_GROUP_MUTE: prdata = {31'd0, unbound_group_mute_q};
			REG_UNBOUND_GROUP_GAIN: prdata = {16'd0, unbound_group_gain_q};
			REG_BOUND_GROUP_MUTE:   prdata = {31'd0, bound_group_mute_q};
			REG_BOUND_GROUP_GAIN:   prdata = {16'd0, bound_group_gain_q};
			default:                prdata = 32'd0;
		endcase
	end

	// ---------------- sequencer control ----------------
	st_t  state_q, state_d;
	logic req_acc;
	logic rsp_acc;
	logic rsp_load;
	logic mem_we;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req_valid) state_d = ST_READ;
			ST_READ: state_d = ST_MUL;
			ST_MUL:  if (!rsp_valid || !rsp_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- request decode at accept ----------------
	logic              idx_ok;
	logic [1:0]        sbank;
	logic              exists;
	logic [ADDR_W-1:0] addr;

	assign idx_ok = {1'b0, track_index} < TRACK_LIM;

	// slot bank: key mode picks draft only for bank 1, bgm mode uses bank 2
	always_comb begin
		priority if (mode == MODE_KEY_EFF) begin
			sbank = (bank == BANK_DRAFT) ? BANK_DRAFT : BANK_PLAYER;
		end else if (mode == MODE_BGM_EFF) begin
			sbank = BANK_BGM;
		end else begin
			sbank = bank;
		end
	end

	assign exists = idx_ok && (sbank <= BANK_BGM);
	assign addr   = ADDR_W'(32'(sbank) * TRACKS) + ADDR_W'(track_index);

	// request fields held for the sequencer
	logic [2:0]        mode_q;
	logic              idx_ok_q, exists_q, draft_q;
	logic              mute_value_q, grp_q, key_en_q;
	logic [15:0]       gain_value_q;
	logic [ADDR_W-1:0] addr_q;

	always_ff @(posedge clk) begin
		if (req_acc) begin
			mode_q       <= mode;
			idx_ok_q     <= idx_ok;
			exists_q     <= exists;
			draft_q      <= (sbank == BANK_DRAFT);
			mute_value_q <= mute_value;
			gain_value_q <= gain_value;
			grp_q        <= effect_group;
			key_en_q     <= key_enabled;
			addr_q       <= addr;
		end
	end

	// ---------------- slot table ----------------
	slot_t      slot_mem [DEPTH];
	logic       slot_vld_q [DEPTH];
	slot_t      rd_data_q;
	logic       rd_vld_q;
	slot_t      wr_data;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[addr_q] <= wr_data;
		end
		if (req_acc && exists) begin
			rd_data_q <= slot_mem[addr];
		end
	end

	// written-since-reset flags: an unwritten slot reads as the reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) slot_vld_q[i] <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) slot_vld_q[addr_q] <= 1'b1;
			if (req_acc) rd_vld_q <= exists && slot_vld_q[addr];
		end
	end

	// ---------------- read cycle: merge, decide, multiply ----------------
	slot_t       cur;
	slot_t       slot_out;
	logic        is_set;
	logic        any_mute;
	logic [15:0] tg;
	logic [15:0] gg;
	logic [15:0] mul_a, mul_b;
	logic [31:0] mul_p;
	logic [16:0] eff_pre;
	logic        use_prod;

	assign cur    = rd_vld_q ? rd_data_q : SLOT_RESET;
	assign is_set = (mode_q == MODE_SET_MUTE) || (mode_q == MODE_SET_GAIN) ||
	                (mode_q == MODE_SET_BOTH);

	// new slot contents for the set modes
	always_comb begin
		wr_data = cur;
		if (mode_q == MODE_SET_MUTE || mode_q == MODE_SET_BOTH) wr_data.mute = mute_value_q;
		if (mode_q == MODE_SET_GAIN || mode_q == MODE_SET_BOTH) wr_data.gain = gain_value_q;
	end

	// slot as reported after the request
	always_comb begin
		priority if (!exists_q) begin
			slot_out = SLOT_RESET;
		end else if (is_set) begin
			slot_out = wr_data;
		end else begin
			slot_out = cur;
		end
	end

	assign tg = exists_q ? cur.gain : UNITY_GAIN;
	assign gg = grp_q ? bound_group_gain_q : unbound_group_gain_q;

	// effective gain: a fixed value, or the product from the shared multiplier
	always_comb begin
		any_mute = 1'b0;
		eff_pre  = 17'd0;
		use_prod = 1'b0;
		mul_a    = tg;
		mul_b    = gg;
		priority if (mode_q == MODE_KEY_EFF) begin
			any_mute = (draft_q ? draft_area_mute_q : player_area_mute_q) ||
			           (exists_q && cur.mute) ||
			           (grp_q ? bound_group_mute_q : unbound_group_mute_q);
			if (!key_en_q) begin
				eff_pre = {1'b0, UNITY_GAIN};
			end else if (!any_mute) begin
				use_prod = 1'b1;
			end
		end else if (mode_q == MODE_BGM_EFF) begin
			mul_a = bgm_area_gain_q;
			mul_b = tg;
			priority if (bgm_area_mute_q) begin
				eff_pre = 17'd0;
			end else if (!idx_ok_q) begin
				eff_pre = {1'b0, bgm_area_gain_q};
			end else if (!cur.mute) begin
				use_prod = 1'b1;
			end
		end else begin
			eff_pre = 17'd0;
		end
	end

	assign mul_p = 32'(mul_a) * 32'(mul_b);

	slot_t       slot_s2;
	logic [16:0] eff_pre_s2;
	logic [16:0] prod_s2;
	logic        use_prod_s2;

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			slot_s2     <= slot_out;
			eff_pre_s2  <= eff_pre;
			prod_s2     <= mul_p[31:15];
			use_prod_s2 <= use_prod;
		end
	end

	// ---------------- sequencer outputs ----------------
	always_comb begin
		req_stall = 1'b1;
		mem_we    = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: req_stall = 1'b0;
			ST_READ: mem_we    = is_set && exists_q;
			ST_MUL:  rsp_load  = !rsp_valid || !rsp_stall;
			default: req_stall = 1'b1;
		endcase
	end

	// ---------------- response register ----------------
	logic idx_ok_s2;

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			idx_ok_s2 <= idx_ok_q;
		end
		if (rsp_load) begin
			slot_muted     <= slot_s2.mute;
			slot_gain      <= slot_s2.gain;
			effective_gain <= use_prod_s2 ? prod_s2 : eff_pre_s2;
			index_valid    <= idx_ok_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid <= 1'b1;
		end else if (rsp_acc) begin
			rsp_valid <= 1'b0;
		end
	end

	// ---------------- assertions ----------------
	a_oor_unity: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !index_valid |-> !slot_muted && slot_gain == UNITY_GAIN)
		else $error("out-of-range response does not report a unity slot");

	a_we_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ST_READ && exists_q && is_set)
		else $error("slot table written outside a set request");

	a_mul_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL && !rsp_stall |=> rsp_valid && state_q == ST_IDLE)
		else $error("finished request did not reach the response register");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> state_q == ST_READ && !req_stall == 1'b0)
		else $error("accepted request did not start a table read");

endmodule

// ----- tb/gain_table_monitor.sv -----
// Watches the request, response and configuration ports of the gain table.
// Keeps its own copy of the slot table and the area/group registers, works
// out the response of every accepted request and checks responses in order.
module gain_table_monitor
	import mgcb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [2:0]  mode,
	input  logic [1:0]  bank,
	input  logic [7:0]  track_index,
	input  logic        mute_value,
	input  logic [15:0] gain_value,
	input  logic        effect_group,
	input  logic        key_enabled,
	// response channel
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic        slot_muted,
	input  logic [15:0] slot_gain,
	input  logic [16:0] effective_gain,
	input  logic        index_valid,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	// status for the stimulus side
	output int          err_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  mode;
		logic [1:0]  bank;
		logic [7:0]  track;
		logic        mute;
		logic [15:0] gain;
		logic        grp;
		logic        en;
	} request_t;

	typedef struct packed {
		logic        muted;
		logic [15:0] gain;
		logic [16:0] eff;
		logic        in_range;
	} answer_t;

	// shadow copy of the slot table and the registers
	logic        trk_mute [BANKS][TRACKS];
	logic [15:0] trk_gain [BANKS][TRACKS];
	logic        player_mute_r, draft_mute_r, bgm_mute_r;
	logic        unbound_mute_r, bound_mute_r;
	logic [15:0] bgm_gain_r, unbound_gain_r, bound_gain_r;

	answer_t due_answers [$];
	answer_t oldest;
	int      fails;

	// Q1.15 multiply, truncated to 15 fraction bits
	function automatic logic [16:0] q15_mul(input logic [16:0] a, input logic [15:0] b);
		logic [32:0] p;
		p = a * b;
		return p[31:15];
	endfunction

	// applies one request to the shadow table and returns its response
	function automatic answer_t resolve_request(input request_t r);
		answer_t     a;
		logic        in_range;
		logic        draft;
		logic        any_mute;
		logic [1:0]  sel;
		logic [15:0] tg;
		logic [15:0] gg;
		in_range = {1'b0, r.track} < TRACK_LIM;
		sel = r.bank;
		a.eff = '0;
		case (r.mode)
			MODE_SET_MUTE, MODE_SET_GAIN, MODE_SET_BOTH: begin
				if (in_range && int'(r.bank) < BANKS) begin
					if (r.mode != MODE_SET_GAIN)
						trk_mute[r.bank][r.track] = r.mute;
					if (r.mode != MODE_SET_MUTE)
						trk_gain[r.bank][r.track] = r.gain;
				end
			end
			MODE_KEY_EFF: begin
				// only the draft code selects draft, all else is player
				draft = r.bank == BANK_DRAFT;
				sel = draft ? BANK_DRAFT : BANK_PLAYER;
				if (!r.en) begin
					a.eff = 17'(UNITY_GAIN);
				end else begin
					any_mute = (draft ? draft_mute_r : player_mute_r)
						|| (in_range && trk_mute[sel][r.track])
						|| (r.grp ? bound_mute_r : unbound_mute_r);
					tg = in_range ? trk_gain[sel][r.track] : UNITY_GAIN;
					gg = r.grp ? bound_gain_r : unbound_gain_r;
					if (!any_mute)
						a.eff = q15_mul(q15_mul(17'(UNITY_GAIN), tg), gg);
				end
			end
			MODE_BGM_EFF: begin
				sel = BANK_BGM;
				if (bgm_mute_r)
					a.eff = '0;
				else if (!in_range)
					a.eff = 17'(bgm_gain_r);
				else if (!trk_mute[BANK_BGM][r.track])
					a.eff = q15_mul(17'(bgm_gain_r), trk_gain[BANK_BGM][r.track]);
			end
			default: ;
		endcase
		// slot fields report the addressed slot after the update
		if (in_range && int'(sel) < BANKS) begin
			a.muted = trk_mute[sel][r.track];
			a.gain = trk_gain[sel][r.track];
		end else begin
			a.muted = 1'b0;
			a.gain = UNITY_GAIN;
		end
		a.in_range = in_range;
		return a;
	endfunction

	task automatic check_field(input string name, input logic [16:0] want,
		input logic [16:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BANKS; b++)
				for (int t = 0; t < TRACKS; t++) begin
					trk_mute[b][t] = 1'b0;
					trk_gain[b][t] = UNITY_GAIN;
				end
			player_mute_r = 1'b0;
			draft_mute_r = 1'b0;
			bgm_mute_r = 1'b0;
			unbound_mute_r = 1'b0;
			bound_mute_r = 1'b0;
			bgm_gain_r = UNITY_GAIN;
			unbound_gain_r = UNITY_GAIN;
			bound_gain_r = UNITY_GAIN;
			due_answers.delete();
			fails = 0;
			err_count <= 0;
			pending <= 0;
		end else begin
			// response first, so a request in the same cycle queues behind it
			if (rsp_valid && !rsp_stall) begin
				if (due_answers.size() == 0) begin
					$error("response with no request outstanding");
					fails++;
				end else begin
					oldest = due_answers.pop_front();
					check_field("slot_muted", 17'(oldest.muted), 17'(slot_muted));
					check_field("slot_gain", 17'(oldest.gain), 17'(slot_gain));
					check_field("effective_gain", oldest.eff, effective_gain);
					check_field("index_valid", 17'(oldest.in_range), 17'(index_valid));
				end
			end
			if (req_valid && !req_stall)
				due_answers.push_back(resolve_request(request_t'{mode, bank, track_index,
					mute_value, gain_value, effect_group, key_enabled}));
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_PLAYER_AREA_MUTE:   player_mute_r = pwdata[0];
					REG_DRAFT_AREA_MUTE:    draft_mute_r = pwdata[0];
					REG_BGM_AREA_MUTE:      bgm_mute_r = pwdata[0];
					REG_BGM_AREA_GAIN:      bgm_gain_r = pwdata[15:0];
					REG_UNBOUND_GROUP_MUTE: unbound_mute_r = pwdata[0];
					REG_UNBOUND_GROUP_GAIN: unbound_gain_r = pwdata[15:0];
					REG_BOUND_GROUP_MUTE:   bound_mute_r = pwdata[0];
					REG_BOUND_GROUP_GAIN:   bound_gain_r = pwdata[15:0];
					default: ;
				endcase
			end
			err_count <= fails;
			pending <= due_answers.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
module tb_top
	import mgcb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// codes with no name in the package
	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;
	localparam logic [1:0] BANK_NONE  = 2'd3;

	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 125;
	localparam int SETTLE         = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [2:0]  mode;
	logic [1:0]  bank;
	logic [7:0]  track_index;
	logic        mute_value;
	logic [15:0] gain_value;
	logic        effect_group;
	logic        key_enabled;
	logic        rsp_valid;
	logic        rsp_stall;
	logic        slot_muted;
	logic [15:0] slot_gain;
	logic [16:0] effective_gain;
	logic        index_valid;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int err_count;
	int pending;
	int idle_cycles = 0;
	bit calm = 1'b0;

	mute_gain_control_bank uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.mode(mode), .bank(bank), .track_index(track_index),
		.mute_value(mute_value), .gain_value(gain_value),
		.effect_group(effect_group), .key_enabled(key_enabled),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.slot_muted(slot_muted), .slot_gain(slot_gain),
		.effective_gain(effective_gain), .index_valid(index_valid),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	gain_table_monitor chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.mode(mode), .bank(bank), .track_index(track_index),
		.mute_value(mute_value), .gain_value(gain_value),
		.effect_group(effect_group), .key_enabled(key_enabled),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.slot_muted(slot_muted), .slot_gain(slot_gain),
		.effective_gain(effective_gain), .index_valid(index_valid),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.err_count(err_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ends the run when nothing moves for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// gap before a request: mostly none or short, now and then long
	function automatic int idle_gap();
		int r;
		r = $urandom_range(99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return UNITY_GAIN;
			default: return 16'($urandom());
		endcase
	endfunction

	// response stall: short bursts mostly, a few long ones
	initial begin
		int r;
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(99);
			if (calm || r < 65) begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b1;
				if (r < 92)
					repeat ($urandom_range(1, 3)) @(posedge clk);
				else if (r < 98)
					repeat ($urandom_range(4, 12)) @(posedge clk);
				else
					repeat ($urandom_range(20, 40)) @(posedge clk);
			end
		end
	end

	// one request, held until accepted
	task automatic issue_request(input logic [2:0] m, input logic [1:0] b,
		input logic [7:0] t, input logic mv, input logic [15:0] g,
		input logic grp, input logic en);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode <= m;
		bank <= b;
		track_index <= t;
		mute_value <= mv;
		gain_value <= g;
		effect_group <= grp;
		key_enabled <= en;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// setup and access phases, then psel low again; upper data bits are noise
	task automatic apb_write(input logic [2:0] idx, input logic [15:0] v, input bit wide);
		logic [31:0] junk;
		junk = $urandom();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= wide ? {junk[31:16], v} : {junk[31:1], v[0]};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// phase 1 all gains max, phase 2 all gains zero, phase 3 all muted
	task automatic program_phase(input int phase);
		logic        pm, dm, bm, um, gm;
		logic [15:0] bg, ug, gg;
		pm = $urandom_range(3) == 0;
		dm = $urandom_range(3) == 0;
		bm = $urandom_range(3) == 0;
		um = $urandom_range(3) == 0;
		gm = $urandom_range(3) == 0;
		bg = pick_gain();
		ug = pick_gain();
		gg = pick_gain();
		case (phase)
			1: begin
				{pm, dm, bm, um, gm} = '0;
				{bg, ug, gg} = {3{16'hFFFF}};
			end
			2: begin
				{pm, dm, bm, um, gm} = '0;
				{bg, ug, gg} = '0;
			end
			3: begin
				{pm, dm, bm, um, gm} = '1;
			end
			default: ;
		endcase
		apb_write(REG_PLAYER_AREA_MUTE, 16'(pm), 1'b0);
		apb_write(REG_DRAFT_AREA_MUTE, 16'(dm), 1'b0);
		apb_write(REG_BGM_AREA_MUTE, 16'(bm), 1'b0);
		apb_write(REG_BGM_AREA_GAIN, bg, 1'b1);
		apb_write(REG_UNBOUND_GROUP_MUTE, 16'(um), 1'b0);
		apb_write(REG_UNBOUND_GROUP_GAIN, ug, 1'b1);
		apb_write(REG_BOUND_GROUP_MUTE, 16'(gm), 1'b0);
		apb_write(REG_BOUND_GROUP_GAIN, gg, 1'b1);
	endtask

	// drain all responses, then let the sequencer settle
	task automatic finish_phase();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic directed_requests();
		localparam logic [7:0] LAST = 8'(TRACKS - 1);
		localparam logic [7:0] OUT  = 8'(TRACKS);
		// reset contents, slot writes and reads at both index extremes
		issue_request(MODE_READ, BANK_PLAYER, 8'd0, 1'b0, 16'h0000, 1'b0, 1'b1);
		issue_request(MODE_SET_BOTH, BANK_PLAYER, 8'd0, 1'b0, 16'hFFFF, 1'b0, 1'b1);
		issue_request(MODE_READ, BANK_PLAYER, 8'd0, 1'b1, 16'h1234, 1'b1, 1'b0);
		issue_request(MODE_SET_GAIN, BANK_DRAFT, LAST, 1'b1, 16'h0000, 1'b0, 1'b1);
		issue_request(MODE_READ, BANK_DRAFT, LAST, 1'b0, 16'h0000, 1'b0, 1'b1);
		// background music slot mute and gain
		issue_request(MODE_SET_MUTE, BANK_BGM, 8'd5, 1'b1, 16'h0000, 1'b0, 1'b1);
		issue_request(MODE_BGM_EFF, BANK_BGM, 8'd5, 1'b0, 16'h0000, 1'b1, 1'b0);
		issue_request(MODE_SET_MUTE, BANK_BGM, 8'd5, 1'b0, 16'hFFFF, 1'b0, 1'b1);
		issue_request(MODE_SET_GAIN, BANK_BGM, 8'd5, 1'b1, 16'hFFFF, 1'b0, 1'b1);
		issue_request(MODE_BGM_EFF, BANK_NONE, 8'd5, 1'b0, 16'h0000, 1'b0, 1'b1);
		issue_request(MODE_BGM_EFF, BANK_PLAYER, 8'd255, 1'b0, 16'h0000, 1'b0, 1'b1);
		// out-of-range index and the nonexistent bank are ignored
		issue_request(MODE_SET_BOTH, BANK_PLAYER, OUT, 1'b1, 16'h0000, 1'b0, 1'b1);
		issue_request(MODE_READ, BANK_PLAYER, OUT, 1'b0, 16'h0000, 1'b0, 1'b1);
		issue_request(MODE_SET_BOTH, BANK_NONE, 8'd1, 1'b1, 16'h0000, 1'b0, 1'b1);
		issue_request(MODE_READ, BANK_NONE, 8'd1, 1'b0, 16'h0000, 1'b0, 1'b1);
		// key effective gain: bank selection, groups, bypass
		issue_request(MODE_KEY_EFF, BANK_PLAYER, 8'd0, 1'b0, 16'h0000, 1'b0, 1'b1);
		issue_request(MODE_KEY_EFF, BANK_BGM, 8'd0, 1'b0, 16'h0000, 1'b1, 1'b1);
		issue_request(MODE_KEY_EFF, BANK_NONE, 8'd0, 1'b0, 16'h0000, 1'b0, 1'b1);
		issue_request(MODE_KEY_EFF, BANK_DRAFT, LAST, 1'b0, 16'h0000, 1'b1, 1'b1);
		issue_request(MODE_SET_MUTE, BANK_PLAYER, 8'd0, 1'b1, 16'h0000, 1'b0, 1'b1);
		issue_request(MODE_KEY_EFF, BANK_PLAYER, 8'd0, 1'b0, 16'h0000, 1'b0, 1'b0);
		issue_request(MODE_KEY_EFF, BANK_PLAYER, 8'd0, 1'b0, 16'h0000, 1'b0, 1'b1);
		issue_request(MODE_KEY_EFF, BANK_PLAYER, 8'd200, 1'b0, 16'h0000, 1'b1, 1'b1);
		// reserved modes behave as reads and must not write
		issue_request(MODE_RSVD6, BANK_PLAYER, 8'd0, 1'b0, 16'h4000, 1'b0, 1'b1);
		issue_request(MODE_RSVD7, BANK_DRAFT, LAST, 1'b1, 16'h7FFF, 1'b1, 1'b1);
		issue_request(MODE_READ, BANK_PLAYER, 8'd0, 1'b0, 16'h0000, 1'b0, 1'b1);
	endtask

	// random request; a few hot slots so writes are read back often
	task automatic random_request();
		logic [2:0]  m;
		logic [1:0]  b;
		logic [7:0]  t;
		int          r;
		r = $urandom_range(99);
		if (r < 15)
			m = MODE_SET_MUTE;
		else if (r < 30)
			m = MODE_SET_GAIN;
		else if (r < 42)
			m = MODE_SET_BOTH;
		else if (r < 57)
			m = MODE_READ;
		else if (r < 77)
			m = MODE_KEY_EFF;
		else if (r < 95)
			m = MODE_BGM_EFF;
		else if (r < 97)
			m = MODE_RSVD6;
		else
			m = MODE_RSVD7;
		b = ($urandom_range(19) == 0) ? BANK_NONE : 2'($urandom_range(0, 2));
		r = $urandom_range(99);
		if (r < 70)
			t = 8'($urandom_range(0, 7));
		else if (r < 80)
			t = 8'($urandom_range(0, TRACKS - 1));
		else if (r < 88)
			t = 8'(TRACKS - 1);
		else
			t = 8'($urandom_range(TRACKS, 255));
		issue_request(m, b, t, $urandom_range(3) == 0, pick_gain(),
			1'($urandom_range(1)), $urandom_range(7) != 0);
	endtask

	initial begin
		int phase;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		mode <= MODE_READ;
		bank <= BANK_PLAYER;
		track_index <= '0;
		mute_value <= 1'b0;
		gain_value <= '0;
		effect_group <= 1'b0;
		key_enabled <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase 0 runs at reset settings, later phases reprogram the registers
		for (phase = 0; phase < PHASES; phase++) begin
			calm = 1'b0;
			if (phase == 0)
				directed_requests();
			else
				program_phase(phase);
			calm = (phase == 2) || (phase == 6);
			repeat (PHASE_ITEMS) random_request();
			finish_phase();
		end

		if (err_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/mgcb_pkg.sv
rtl/mute_gain_control_bank.sv
tb/gain_table_monitor.sv
tb/tb_top.sv
